// ===== rtl/dpb_pkg.sv =====
// shared types and constants for the depth pixel backprojection unit
// no dependencies; used by depth_pixel_backprojection_unit

package dpb_pkg;

   localparam int unsigned DEPTH_W  = 16;
   localparam int unsigned PIX_W    = 12;
   localparam int unsigned SCALE_W  = 24;
   localparam int unsigned CENTER_W = 16;
   localparam int unsigned Z_W      = 20;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam int unsigned MAX_ROWS = 4096;
   localparam int unsigned MAX_COLS = 4096;

   // 0.01 m and 10 m in Q17.16
   localparam logic [32:0] Z_MIN = 33'd655;
   localparam logic [32:0] Z_MAX = 33'd655360;

   localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RST = 24'd16777;
   localparam logic [SCALE_W-1:0]  INV_FOCAL_X_RST = 24'd27131;
   localparam logic [SCALE_W-1:0]  INV_FOCAL_Y_RST = 24'd27134;
   localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd5317;
   localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3935;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_SCALE = 3'd0,
      CSR_INV_FOCAL_X = 3'd1,
      CSR_INV_FOCAL_Y = 3'd2,
      CSR_CENTER_X    = 3'd3,
      CSR_CENTER_Y    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_raw;
      logic [PIX_W-1:0]   pixel_row;
      logic [PIX_W-1:0]   pixel_col;
   } req_data_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [Z_W-1:0]            point_z;
      logic [PIX_W-1:0]          source_row;
      logic [PIX_W-1:0]          source_col;
   } rsp_data_type;

endpackage

// ===== rtl/depth_pixel_backprojection_unit.sv =====
// depth pixel to 3-d point backprojection, five-stage pipeline
// depends on dpb_pkg for payload types, register indexes and constants
//
// Usage: a pixel transfer happens at a clock edge with start high and busy low.
// busy is high only during reset, so one pixel can be taken every cycle and
// the sustained rate is one pixel per clock. Each pixel with row and column
// below MAX_ROWS and MAX_COLS whose depth maps into the 0.01 m to 10 m window
// gives one point on rsp_data, marked by a one-cycle rsp_valid strobe; any
// other pixel gives nothing and leaves no gap in the pipeline. The stages
// follow the multiplier chain: depth scale, window check, offset times depth,
// times focal reciprocal, then round and saturate, one register stage each.
// The receiver cannot stall, so no backpressure exists and nothing is held.
// Camera registers are written through csr_we, csr_index and csr_wdata and
// take effect at once; write them only while no pixel is in flight.
// Reset clears the pipeline valid bits and loads the default camera model.

module depth_pixel_backprojection_unit #(
   parameter int unsigned MAX_ROWS = dpb_pkg::MAX_ROWS,
   parameter int unsigned MAX_COLS = dpb_pkg::MAX_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  dpb_pkg::req_data_type                req_data,
   output logic                                 rsp_valid,
   output dpb_pkg::rsp_data_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dpb_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int unsigned ZPROD_W = dpb_pkg::DEPTH_W + dpb_pkg::SCALE_W;
   localparam int unsigned MAG_W   = dpb_pkg::CENTER_W;
   localparam int unsigned P1_W    = MAG_W + dpb_pkg::Z_W;
   localparam int unsigned P2_W    = P1_W + dpb_pkg::SCALE_W;
   localparam int unsigned Q_W     = P2_W + 1 - 28;

   // config registers
   logic [dpb_pkg::SCALE_W-1:0]  depth_scale_ff;
   logic [dpb_pkg::SCALE_W-1:0]  inv_focal_x_ff;
   logic [dpb_pkg::SCALE_W-1:0]  inv_focal_y_ff;
   logic [dpb_pkg::CENTER_W-1:0] center_x_ff;
   logic [dpb_pkg::CENTER_W-1:0] center_y_ff;

   // pipeline registers
   logic                       s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [ZPROD_W-1:0]         s1_zprod_ff;
   logic                       s1_xneg_ff, s2_xneg_ff, s3_xneg_ff, s4_xneg_ff;
   logic                       s1_yneg_ff, s2_yneg_ff, s3_yneg_ff, s4_yneg_ff;
   logic [MAG_W-1:0]           s1_xmag_ff, s2_xmag_ff;
   logic [MAG_W-1:0]           s1_ymag_ff, s2_ymag_ff;
   logic [dpb_pkg::PIX_W-1:0]  s1_row_ff, s2_row_ff, s3_row_ff, s4_row_ff;
   logic [dpb_pkg::PIX_W-1:0]  s1_col_ff, s2_col_ff, s3_col_ff, s4_col_ff;
   logic [dpb_pkg::Z_W-1:0]    s2_z_ff, s3_z_ff, s4_z_ff;
   logic [P1_W-1:0]            s3_xprod_ff, s3_yprod_ff;
   logic [P2_W-1:0]            s4_xprod_ff, s4_yprod_ff;
   logic                       rsp_valid_ff;
   dpb_pkg::rsp_data_type      rsp_data_ff;

   // next values
   logic                       accept_in;
   logic                       s1_valid_in, s2_valid_in;
   logic [ZPROD_W-1:0]         s1_zprod_in;
   logic [15:0]                xp16_in, yp16_in;
   logic                       s1_xneg_in, s1_yneg_in;
   logic [MAG_W-1:0]           s1_xmag_in, s1_ymag_in;
   logic [ZPROD_W:0]           zsum_in;
   logic [32:0]                zfull_in;
   logic [P1_W-1:0]            s3_xprod_in, s3_yprod_in;
   logic [P2_W-1:0]            s4_xprod_in, s4_yprod_in;
   dpb_pkg::rsp_data_type      rsp_data_in;

   function automatic logic [dpb_pkg::COORD_W-1:0] round_sat(
      input logic [P2_W-1:0] prod,
      input logic            neg
   );
      logic [P2_W:0]  sum;
      logic [Q_W-1:0] q;
      sum = {1'b0, prod} + (P2_W+1)'(64'd1 << 27);
      q   = sum[P2_W:28];
      if (neg) begin
         if (q > Q_W'(64'h8000_0000)) begin
            q = Q_W'(64'h8000_0000);
         end
         round_sat = dpb_pkg::COORD_W'(Q_W'(0) - q);
      end else begin
         if (q > Q_W'(64'h7FFF_FFFF)) begin
            q = Q_W'(64'h7FFF_FFFF);
         end
         round_sat = q[dpb_pkg::COORD_W-1:0];
      end
   endfunction

   assign busy      = reset;
   assign accept_in = start && !busy;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= dpb_pkg::DEPTH_SCALE_RST;
         inv_focal_x_ff <= dpb_pkg::INV_FOCAL_X_RST;
         inv_focal_y_ff <= dpb_pkg::INV_FOCAL_Y_RST;
         center_x_ff    <= dpb_pkg::CENTER_X_RST;
         center_y_ff    <= dpb_pkg::CENTER_Y_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dpb_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata;
            dpb_pkg::CSR_CENTER_X:    center_x_ff <= csr_wdata[dpb_pkg::CENTER_W-1:0];
            dpb_pkg::CSR_CENTER_Y:    center_y_ff <= csr_wdata[dpb_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: depth scale and pixel offsets
   always_comb begin
      s1_valid_in = accept_in
         && ({5'b0, req_data.pixel_row} < 17'(MAX_ROWS))
         && ({5'b0, req_data.pixel_col} < 17'(MAX_COLS));
      s1_zprod_in = ZPROD_W'(req_data.depth_raw) * ZPROD_W'(depth_scale_ff);
      xp16_in     = {req_data.pixel_col, 4'b0000};
      yp16_in     = {req_data.pixel_row, 4'b0000};
      s1_xneg_in  = xp16_in < center_x_ff;
      s1_yneg_in  = yp16_in < center_y_ff;
      s1_xmag_in  = s1_xneg_in ? (center_x_ff - xp16_in) : (xp16_in - center_x_ff);
      s1_ymag_in  = s1_yneg_in ? (center_y_ff - yp16_in) : (yp16_in - center_y_ff);
   end

   // stage 2: round z, depth window
   always_comb begin
      zsum_in     = {1'b0, s1_zprod_ff} + (ZPROD_W+1)'(128);
      zfull_in    = zsum_in[ZPROD_W:8];
      s2_valid_in = s1_valid_ff && (zfull_in >= dpb_pkg::Z_MIN)
                    && (zfull_in <= dpb_pkg::Z_MAX);
   end

   // stage 3 and 4: offset times depth, then times focal reciprocal
   assign s3_xprod_in = P1_W'(s2_xmag_ff) * P1_W'(s2_z_ff);
   assign s3_yprod_in = P1_W'(s2_ymag_ff) * P1_W'(s2_z_ff);
   assign s4_xprod_in = P2_W'(s3_xprod_ff) * P2_W'(inv_focal_x_ff);
   assign s4_yprod_in = P2_W'(s3_yprod_ff) * P2_W'(inv_focal_y_ff);

   // stage 5: round, sign and saturate
   always_comb begin
      rsp_data_in.point_x    = round_sat(s4_xprod_ff, s4_xneg_ff);
      rsp_data_in.point_y    = round_sat(s4_yprod_ff, s4_yneg_ff);
      rsp_data_in.point_z    = s4_z_ff;
      rsp_data_in.source_row = s4_row_ff;
      rsp_data_in.source_col = s4_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_zprod_ff <= s1_zprod_in;
      s1_xneg_ff  <= s1_xneg_in;
      s1_yneg_ff  <= s1_yneg_in;
      s1_xmag_ff  <= s1_xmag_in;
      s1_ymag_ff  <= s1_ymag_in;
      s1_row_ff   <= req_data.pixel_row;
      s1_col_ff   <= req_data.pixel_col;

      s2_z_ff     <= zfull_in[dpb_pkg::Z_W-1:0];
      s2_xneg_ff  <= s1_xneg_ff;
      s2_yneg_ff  <= s1_yneg_ff;
      s2_xmag_ff  <= s1_xmag_ff;
      s2_ymag_ff  <= s1_ymag_ff;
      s2_row_ff   <= s1_row_ff;
      s2_col_ff   <= s1_col_ff;

      s3_xprod_ff <= s3_xprod_in;
      s3_yprod_ff <= s3_yprod_in;
      s3_xneg_ff  <= s2_xneg_ff;
      s3_yneg_ff  <= s2_yneg_ff;
      s3_z_ff     <= s2_z_ff;
      s3_row_ff   <= s2_row_ff;
      s3_col_ff   <= s2_col_ff;

      s4_xprod_ff <= s4_xprod_in;
      s4_yprod_ff <= s4_yprod_in;
      s4_xneg_ff  <= s3_xneg_ff;
      s4_yneg_ff  <= s3_yneg_ff;
      s4_z_ff     <= s3_z_ff;
      s4_row_ff   <= s3_row_ff;
      s4_col_ff   <= s3_col_ff;

      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // emitted depth always inside the window
   a_z_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({13'd0, rsp_data.point_z} >= dpb_pkg::Z_MIN)
                    && ({13'd0, rsp_data.point_z} <= dpb_pkg::Z_MAX))
      else $error("point_z outside depth window");

   // reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // zero depth never yields a point
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.depth_raw == '0)) |-> ##5 !rsp_valid)
      else $error("point emitted for zero depth");

   // result only follows an occupied last stage
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s4_valid_ff))
      else $error("result strobe without pipeline occupancy");

endmodule
